// ----- rtl/vrs_pkg.sv -----
// Package for the variation region scalar block.
// Holds fixed-point widths, the per-axis op record and the back-end state type.
// No dependencies.
package vrs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FW        = FRAC_BITS + 1;   // factor and product width, Q1.FRAC_BITS
	localparam int CW        = 16;              // F2Dot14 field width
	localparam int OW        = 17;              // Q1.16 result width
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int DCNT_W    = $clog2(FRAC_BITS + 1);
	localparam int Q16_SHR   = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
	localparam int Q16_SHL   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

	typedef logic [FW-1:0] fix_t;

	localparam fix_t ONE_FIX = fix_t'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		FK_ONE,
		FK_ZERO,
		FK_RAMP
	} fkind_t;

	// classified axis record: ramp numerator and divisor, both positive
	typedef struct packed {
		fkind_t        kind;
		logic [CW-1:0] num;
		logic [CW-1:0] den;
		logic          last;
	} vrs_op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_MUL,
		BK_DONE
	} bk_state_t;

	function automatic logic [OW-1:0] to_q16(input fix_t p);
		logic [FW+Q16_SHL-1:0] w;
		w = (FW + Q16_SHL)'(p) << Q16_SHL;
		return OW'(w >> Q16_SHR);
	endfunction

endpackage

// ----- rtl/vrs_ifs.sv -----
// Valid/ready channel interfaces for the variation region scalar block.
// Depends on vrs_pkg for field widths.
interface vrs_axis_if;
	import vrs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] axis_start;
	logic signed [CW-1:0] axis_peak;
	logic signed [CW-1:0] axis_end;
	logic signed [CW-1:0] axis_coord;
	logic                 region_in_range;
	logic                 last_axis;

	modport source (output valid, axis_start, axis_peak, axis_end, axis_coord,
		region_in_range, last_axis, input ready);
	modport sink (input valid, axis_start, axis_peak, axis_end, axis_coord,
		region_in_range, last_axis, output ready);
endinterface

interface vrs_scalar_if;
	import vrs_pkg::*;
	logic          valid;
	logic          ready;
	logic [OW-1:0] region_scalar;

	modport source (output valid, region_scalar, input ready);
	modport sink (input valid, region_scalar, output ready);
endinterface

// ----- rtl/vrs_front.sv -----
// Front end: accepts axis records and classifies the tent factor rule.
// Depends on vrs_pkg and vrs_axis_if.
module vrs_front (
	vrs_axis_if.sink         axis_rec,
	input  logic             full,
	output logic             push,
	output vrs_pkg::vrs_op_t op
);
	import vrs_pkg::*;

	logic signed [CW-1:0] s, p, e, c;
	logic signed [CW:0]   d_cs, d_ps, d_ec, d_ep;

	assign s = axis_rec.axis_start;
	assign p = axis_rec.axis_peak;
	assign e = axis_rec.axis_end;
	assign c = axis_rec.axis_coord;

	assign axis_rec.ready = !full;
	assign push           = axis_rec.valid && !full;

	assign d_cs = {c[CW-1], c} - {s[CW-1], s};
	assign d_ps = {p[CW-1], p} - {s[CW-1], s};
	assign d_ec = {e[CW-1], e} - {c[CW-1], c};
	assign d_ep = {e[CW-1], e} - {p[CW-1], p};

	always_comb begin
		op.last = axis_rec.last_axis;
		// rising side below peak, falling side otherwise
		if (c < p) begin
			op.num = d_cs[CW-1:0];
			op.den = d_ps[CW-1:0];
		end else begin
			op.num = d_ec[CW-1:0];
			op.den = d_ep[CW-1:0];
		end
		priority if (!axis_rec.region_in_range) begin
			op.kind = FK_ZERO;
		end else if (p == '0 || c == p) begin
			op.kind = FK_ONE;
		end else if (c == '0) begin
			op.kind = FK_ZERO;
		end else if (s > p || p > e) begin
			op.kind = FK_ONE;
		end else if (s < 0 && e > 0) begin
			op.kind = FK_ONE;
		end else if (c <= s || e <= c) begin
			op.kind = FK_ZERO;
		end else begin
			op.kind = FK_RAMP;
		end
	end

endmodule

// ----- rtl/vrs_queue.sv -----
// Short FIFO of classified axis records between front and back end.
// Depends on vrs_pkg.
module vrs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vrs_pkg::vrs_op_t wr_op,
	output logic             full,
	output logic             q_valid,
	output vrs_pkg::vrs_op_t rd_op,
	input  logic             pop
);
	import vrs_pkg::*;

	vrs_op_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_pop;

	assign full    = cnt_q == QCNT_W'(QDEPTH);
	assign q_valid = cnt_q != '0;
	assign rd_op   = mem_q[rd_ptr_q];
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH)) else $error("queue count out of range");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

// ----- rtl/vrs_back.sv -----
// Back end: bit-serial ramp divider, product multiply and result register.
// Depends on vrs_pkg and vrs_scalar_if.
module vrs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  vrs_pkg::vrs_op_t q_op,
	output logic             pop,
	vrs_scalar_if.source     result
);
	import vrs_pkg::*;

	bk_state_t            state_q, state_nxt;
	logic [CW-1:0]        den_q, rem_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [DCNT_W-1:0]    cnt_q;
	fix_t                 factor_q, prod_q;
	logic                 last_q;
	logic                 res_valid_q;
	logic [OW-1:0]        res_q;

	logic                 out_free, load_out, div_end, ge;
	logic [CW:0]          trial;
	logic [2*FW-1:0]      mul;

	assign trial    = {rem_q, 1'b0};
	assign ge       = trial >= {1'b0, den_q};
	assign div_end  = cnt_q == DCNT_W'(FRAC_BITS - 1);
	assign out_free = !res_valid_q || result.ready;
	assign mul      = {{FW{1'b0}}, prod_q} * {{FW{1'b0}}, factor_q};

	assign result.valid         = res_valid_q;
	assign result.region_scalar = res_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: if (q_valid) begin
				state_nxt = (q_op.kind == FK_RAMP) ? BK_DIV : BK_MUL;
			end
			BK_DIV: if (div_end) begin
				state_nxt = BK_MUL;
			end
			BK_MUL: state_nxt = BK_DONE;
			BK_DONE: if (!last_q || out_free) begin
				state_nxt = BK_IDLE;
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: pop = q_valid;
			BK_DONE: load_out = last_q && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			prod_q      <= ONE_FIX;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == BK_MUL) begin
				prod_q <= FW'(mul >> FRAC_BITS);
			end else if (load_out) begin
				prod_q <= ONE_FIX;
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			den_q    <= q_op.den;
			rem_q    <= q_op.num;
			cnt_q    <= '0;
			last_q   <= q_op.last;
			factor_q <= (q_op.kind == FK_ONE) ? ONE_FIX : '0;
		end else if (state_q == BK_DIV) begin
			// restoring division, one quotient bit per cycle
			rem_q <= ge ? CW'(trial - {1'b0, den_q}) : CW'(trial);
			quo_q <= {quo_q[FRAC_BITS-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
			if (div_end) begin
				factor_q <= {1'b0, quo_q[FRAC_BITS-2:0], ge};
			end
		end
		if (load_out) begin
			res_q <= to_q16(prod_q);
		end
	end

	a_prod_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		prod_q <= ONE_FIX) else $error("running product above 1.0");
	a_rem_lt_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DIV |-> rem_q < den_q) else $error("divider remainder not reduced");
	a_factor_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_MUL |-> factor_q <= ONE_FIX) else $error("tent factor above 1.0");
	a_prod_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> prod_q == ONE_FIX) else $error("product not restarted after result");

endmodule

// ----- rtl/variation_region_scalar.sv -----
// Top level of the variation region scalar block: front, queue and back end.
// Depends on vrs_pkg, vrs_ifs, vrs_front, vrs_queue and vrs_back.
//
//  channel    dir  beat contents
//  axis_rec   in   start, peak, end, coord (F2Dot14), region_in_range, last_axis
//  result     out  region_scalar (Q1.16), one beat per region on its last axis
//
// In the back end a ramp axis runs the one-bit-per-cycle divider and then the
// multiply and done states; other axes go from idle straight to the multiply.
// Reset sets the running product to 1.0 and empties the queue.
// Records are taken while the 2-deep queue has room; a waiting result sits in
// the output register and stalls the back end only when the next one is ready.
module variation_region_scalar (
	input  logic         clk,
	input  logic         arst_n,
	vrs_axis_if.sink     axis_rec,
	vrs_scalar_if.source result
);
	import vrs_pkg::*;

	logic    push, full, q_valid, pop;
	vrs_op_t wr_op, rd_op;

	vrs_front u_front (
		.axis_rec (axis_rec),
		.full     (full),
		.push     (push),
		.op       (wr_op)
	);

	vrs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_op   (wr_op),
		.full    (full),
		.q_valid (q_valid),
		.rd_op   (rd_op),
		.pop     (pop)
	);

	vrs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_op    (rd_op),
		.pop     (pop),
		.result  (result)
	);

endmodule
